@@ rtl/atrt_pkg.sv @@
// Package with shared types and constants of the acknowledgement tracker.
`default_nettype none
package atrt_pkg;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int FAIL_DEPTH_DEF = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd100000;
    localparam logic [2:0] RETRIES_RESET = 3'd3;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_ACK = 3'd1;
    localparam logic [2:0] OP_SCAN = 3'd2;
    localparam logic [2:0] OP_RETRY = 3'd3;
    localparam logic [2:0] OP_RESTORE = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_OFFLINE = 2'd2;
    localparam logic [1:0] KIND_MOVED = 2'd3;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRIES = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] msg_id;
        logic [7:0]  unit_index;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] msg_id;
        logic [7:0]  unit;
        logic        ok;
        logic [4:0]  waiting_level;
        logic [4:0]  failed_level;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

@@ rtl/atrt_cmd_queue.sv @@
// Short command queue between the input side and the table engine.
`default_nettype none
module atrt_cmd_queue
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  atrt_pkg::cmd_t   in_cmd,
    output logic             out_valid,
    input  wire              out_ready,
    output atrt_pkg::cmd_t   out_cmd
);
    import atrt_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/atrt_engine.sv @@
// Table engine: walks waiting and failed tables one entry per cycle unless stalled.
`default_nettype none
module atrt_engine
#(
    parameter int WAIT_DEPTH = atrt_pkg::WAIT_DEPTH_DEF,
    parameter int FAIL_DEPTH = atrt_pkg::FAIL_DEPTH_DEF
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  atrt_pkg::cmd_t   cmd,
    input  wire [31:0]       timeout_ms,
    input  wire [2:0]        max_retries,
    output logic             res_valid,
    input  wire              res_ready,
    output atrt_pkg::res_t   res
);
    import atrt_pkg::*;

    localparam int WW = $clog2(WAIT_DEPTH);
    localparam int FW = $clog2(FAIL_DEPTH);
    localparam int WC = $clog2(WAIT_DEPTH + 1);
    localparam int FC = $clog2(FAIL_DEPTH + 1);
    // The walk index serves both tables, so it spans the wider of the two counts.
    localparam int IC = (WC > FC) ? WC : FC;
    localparam logic [IC:0] IDX_ONE = (IC+1)'(1);

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_SHIFTW, S_SHIFTF, S_OUT} state_t;

    logic [31:0] w_id_reg [WAIT_DEPTH];
    logic [7:0]  w_un_reg [WAIT_DEPTH];
    logic [31:0] w_st_reg [WAIT_DEPTH];
    logic [31:0] f_id_reg [FAIL_DEPTH];
    logic [7:0]  f_un_reg [FAIL_DEPTH];
    logic [3:0]  f_tr_reg [FAIL_DEPTH];

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [WC-1:0] wcnt_reg;
    logic [FC-1:0] fcnt_reg;
    logic [IC:0] idx_reg;
    logic [IC:0] sh_reg;
    logic        ok_reg;
    logic [7:0]  sunit_reg;
    logic        after_reg;  // status pending after the current shift
    logic        out_valid_reg;
    res_t        out_reg;
    // event that waits to be emitted after a shift-dependent step
    logic        pend_reg;
    res_t        pend_res_reg;

    logic [WW-1:0] wi;
    logic [FW-1:0] fi;
    logic [IC:0]   wcnt_x;
    logic [IC:0]   fcnt_x;
    logic          out_free;
    logic          out_load;

    assign wi = idx_reg[WW-1:0];
    assign fi = idx_reg[FW-1:0];
    assign wcnt_x = (IC+1)'(wcnt_reg);
    assign fcnt_x = (IC+1)'(fcnt_reg);
    assign out_free = !out_valid_reg || res_ready;
    // The output register is loaded this cycle: a pending event, a resend or the status.
    assign out_load = out_free &&
        (((state_reg == S_WALK) && (pend_reg ||
            ((cmd_reg.op == OP_RETRY) && (idx_reg < fcnt_x)))) ||
         (state_reg == S_OUT));
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    function automatic res_t mk(input logic [1:0] k, input logic [31:0] id,
                                input logic [7:0] u, input logic o,
                                input logic [4:0] wl, input logic [4:0] fl,
                                input logic l);
        res_t r;
        r.kind = k; r.msg_id = id; r.unit = u; r.ok = o;
        r.waiting_level = wl; r.failed_level = fl; r.last = l;
        return r;
    endfunction

    logic [4:0] wl5, fl5;
    assign wl5 = 5'(wcnt_reg);
    assign fl5 = 5'(fcnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wcnt_reg      <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (res_ready && out_valid_reg && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= '0;
                        ok_reg    <= (cmd.op == OP_SCAN) || (cmd.op == OP_RETRY);
                        sunit_reg <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (pend_reg)
                    begin
                        if (out_free)
                        begin
                            out_reg <= pend_res_reg;
                            out_valid_reg <= 1'b1;
                            pend_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        case (cmd_reg.op)
                            OP_ADD:
                            begin
                                sunit_reg <= cmd_reg.unit_index;
                                if ({1'b0, wcnt_reg} < (WC+1)'(WAIT_DEPTH))
                                begin
                                    w_id_reg[wcnt_reg[WW-1:0]] <= cmd_reg.msg_id;
                                    w_un_reg[wcnt_reg[WW-1:0]] <= cmd_reg.unit_index;
                                    w_st_reg[wcnt_reg[WW-1:0]] <= cmd_reg.now_ms;
                                    wcnt_reg <= wcnt_reg + WC'(1);
                                    ok_reg <= 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                            OP_ACK:
                            begin
                                if (idx_reg >= wcnt_x)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (w_id_reg[wi] == cmd_reg.msg_id)
                                begin
                                    sunit_reg <= w_un_reg[wi];
                                    ok_reg <= 1'b1;
                                    sh_reg <= idx_reg;
                                    after_reg <= 1'b1;
                                    state_reg <= S_SHIFTW;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + IDX_ONE;
                                end
                            end
                            OP_SCAN:
                            begin
                                if (idx_reg >= wcnt_x)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if ((cmd_reg.now_ms - w_st_reg[wi]) > timeout_ms)
                                begin
                                    if ({1'b0, fcnt_reg} < (FC+1)'(FAIL_DEPTH))
                                    begin
                                        f_id_reg[fcnt_reg[FW-1:0]] <= w_id_reg[wi];
                                        f_un_reg[fcnt_reg[FW-1:0]] <= w_un_reg[wi];
                                        f_tr_reg[fcnt_reg[FW-1:0]] <= 4'd0;
                                        fcnt_reg <= fcnt_reg + FC'(1);
                                        pend_res_reg <= mk(KIND_MOVED, w_id_reg[wi],
                                            w_un_reg[wi], 1'b0, wl5 - 5'd1,
                                            fl5 + 5'd1, 1'b0);
                                        pend_reg <= 1'b1;
                                        sh_reg <= idx_reg;
                                        after_reg <= 1'b0;
                                        state_reg <= S_SHIFTW;
                                    end
                                    else
                                    begin
                                        ok_reg <= 1'b0;
                                        idx_reg <= idx_reg + IDX_ONE;
                                    end
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + IDX_ONE;
                                end
                            end
                            OP_RETRY:
                            begin
                                if (idx_reg >= fcnt_x)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (out_free)
                                begin
                                    out_reg <= mk(KIND_RESEND, f_id_reg[fi], f_un_reg[fi],
                                        1'b0, wl5, fl5, 1'b0);
                                    out_valid_reg <= 1'b1;
                                    f_tr_reg[fi] <= f_tr_reg[fi] + 4'd1;
                                    if ((f_tr_reg[fi] + 4'd1) > {1'b0, max_retries})
                                    begin
                                        pend_res_reg <= mk(KIND_OFFLINE, f_id_reg[fi],
                                            f_un_reg[fi], 1'b0, wl5, fl5 - 5'd1, 1'b0);
                                        pend_reg <= 1'b1;
                                        sh_reg <= idx_reg;
                                        after_reg <= 1'b0;
                                        state_reg <= S_SHIFTF;
                                    end
                                    else
                                    begin
                                        idx_reg <= idx_reg + IDX_ONE;
                                    end
                                end
                            end
                            OP_RESTORE:
                            begin
                                if (idx_reg >= fcnt_x)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (f_id_reg[fi] == cmd_reg.msg_id)
                                begin
                                    sunit_reg <= f_un_reg[fi];
                                    if ({1'b0, wcnt_reg} < (WC+1)'(WAIT_DEPTH))
                                    begin
                                        w_id_reg[wcnt_reg[WW-1:0]] <= f_id_reg[fi];
                                        w_un_reg[wcnt_reg[WW-1:0]] <= f_un_reg[fi];
                                        w_st_reg[wcnt_reg[WW-1:0]] <= cmd_reg.now_ms;
                                        wcnt_reg <= wcnt_reg + WC'(1);
                                        ok_reg <= 1'b1;
                                        sh_reg <= idx_reg;
                                        after_reg <= 1'b1;
                                        state_reg <= S_SHIFTF;
                                    end
                                    else
                                    begin
                                        state_reg <= S_OUT;
                                    end
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + IDX_ONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SHIFTW:
                begin
                    // Close the gap one entry a cycle, then drop the count.
                    if ((sh_reg + IDX_ONE) < wcnt_x)
                    begin
                        w_id_reg[sh_reg[WW-1:0]] <= w_id_reg[WW'(sh_reg + IDX_ONE)];
                        w_un_reg[sh_reg[WW-1:0]] <= w_un_reg[WW'(sh_reg + IDX_ONE)];
                        w_st_reg[sh_reg[WW-1:0]] <= w_st_reg[WW'(sh_reg + IDX_ONE)];
                        sh_reg <= sh_reg + IDX_ONE;
                    end
                    else
                    begin
                        wcnt_reg <= wcnt_reg - WC'(1);
                        state_reg <= after_reg ? S_OUT : S_WALK;
                    end
                end
                S_SHIFTF:
                begin
                    if ((sh_reg + IDX_ONE) < fcnt_x)
                    begin
                        f_id_reg[sh_reg[FW-1:0]] <= f_id_reg[FW'(sh_reg + IDX_ONE)];
                        f_un_reg[sh_reg[FW-1:0]] <= f_un_reg[FW'(sh_reg + IDX_ONE)];
                        f_tr_reg[sh_reg[FW-1:0]] <= f_tr_reg[FW'(sh_reg + IDX_ONE)];
                        sh_reg <= sh_reg + IDX_ONE;
                    end
                    else
                    begin
                        fcnt_reg <= fcnt_reg - FC'(1);
                        state_reg <= after_reg ? S_OUT : S_WALK;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        // Only add, acknowledge and restore echo the id; all others report 0.
                        out_reg <= mk(KIND_STATUS,
                            ((cmd_reg.op == OP_ADD) || (cmd_reg.op == OP_ACK) ||
                             (cmd_reg.op == OP_RESTORE)) ? cmd_reg.msg_id : 32'd0,
                            sunit_reg, ok_reg, wl5, fl5, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/ack_timeout_retry_tracker_unit.sv @@
// Top level of the acknowledgement timeout and retry tracker.
// An add writes its entry if the table has room and gives its status beat; acknowledge, scan,
// retry and restore walk the tables one entry a cycle while the output does not hold them off,
// and close each gap one entry a cycle.
// Throughput: one command in the engine at a time; a two-entry queue takes commands meanwhile.
// Reset: asynchronous, active low; both tables empty, registers at their defaults.
`default_nettype none
module ack_timeout_retry_tracker_unit
#(
    parameter int WAIT_DEPTH = atrt_pkg::WAIT_DEPTH_DEF,
    parameter int FAIL_DEPTH = atrt_pkg::FAIL_DEPTH_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0], msg_id[34:3], unit_index[42:35], now_ms[74:43], zero fill
    input  wire [79:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_msg_id[31:0], out_unit[39:32], ok[40], waiting_level[45:41],
    // failed_level[50:46], zero fill
    output logic [55:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [31:0]  cfg_data
);
    import atrt_pkg::*;

    logic [31:0] timeout_reg;
    logic [2:0]  retries_reg;
    cmd_t        in_cmd, q_cmd;
    logic        q_valid, q_ready;
    res_t        r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            retries_reg <= RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else if (cfg_index == REG_RETRIES)
            begin
                retries_reg <= cfg_data[2:0];
            end
        end
    end

    assign in_cmd.op         = s_axis_tdata[2:0];
    assign in_cmd.msg_id     = s_axis_tdata[34:3];
    assign in_cmd.unit_index = s_axis_tdata[42:35];
    assign in_cmd.now_ms     = s_axis_tdata[74:43];

    atrt_cmd_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    atrt_engine #(.WAIT_DEPTH(WAIT_DEPTH), .FAIL_DEPTH(FAIL_DEPTH)) u_engine
    (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .timeout_ms(timeout_reg), .max_retries(retries_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tdata = {5'd0, r.failed_level, r.waiting_level, r.ok, r.unit, r.msg_id};
    assign m_axis_tuser = r.kind;
    assign m_axis_tlast = r.last;
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the acknowledgement timeout and retry tracker.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import atrt_pkg::*;

    // Opcodes 5 to 7 are not defined; the block must answer them with a failed status.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED = 3'd7;
    localparam int TABLE_DEPTH = 16;
    // Idle cycles after the last owed beat, so that any extra beat is caught.
    localparam int SETTLE_CYCLES = 400;
    // Cycles without any accepted beat on either side before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int PRESSURE_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_TIMEOUT;
    logic [31:0] cfg_data = '0;

    ack_timeout_retry_tracker_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copy of the tracker: both tables, their fill counts and the two registers.
    logic [31:0] pend_id [TABLE_DEPTH];
    logic [7:0]  pend_unit [TABLE_DEPTH];
    logic [31:0] pend_stamp [TABLE_DEPTH];
    int          pend_n;
    logic [31:0] lost_id [TABLE_DEPTH];
    logic [7:0]  lost_unit [TABLE_DEPTH];
    logic [3:0]  lost_tries [TABLE_DEPTH];
    int          lost_n;
    logic [31:0] timeout_reg;
    logic [2:0]  retries_reg;

    // Beats the tracker still owes us, oldest first.
    res_t owed_beats[$];
    int   error_count = 0;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    function automatic void owe(logic [1:0] kind, logic [31:0] id, logic [7:0] unit,
                                logic ok, logic last);
        res_t r;
        r.kind = kind;
        r.msg_id = id;
        r.unit = unit;
        r.ok = ok;
        r.waiting_level = 5'(pend_n);
        r.failed_level = 5'(lost_n);
        r.last = last;
        owed_beats.push_back(r);
    endfunction

    // Removing an entry shifts everything behind it one slot toward the head.
    function automatic void remove_pending(int k);
        for (int i = k; i + 1 < pend_n; i++) begin
            pend_id[i] = pend_id[i + 1];
            pend_unit[i] = pend_unit[i + 1];
            pend_stamp[i] = pend_stamp[i + 1];
        end
        pend_n--;
    endfunction

    function automatic void remove_lost(int k);
        for (int i = k; i + 1 < lost_n; i++) begin
            lost_id[i] = lost_id[i + 1];
            lost_unit[i] = lost_unit[i + 1];
            lost_tries[i] = lost_tries[i + 1];
        end
        lost_n--;
    endfunction

    // Applies one command to the shadow tables and queues every beat it produces:
    // event beats in table order, then a single closing status beat.
    function automatic void track_command(cmd_t c);
        logic        ok;
        logic [31:0] sid;
        logic [7:0]  sunit;
        logic [31:0] age;
        logic [31:0] mid;
        logic [7:0]  mu;
        int          i;
        ok = 1'b0;
        sid = '0;
        sunit = '0;
        case (c.op)
            OP_ADD:
            begin
                sid = c.msg_id;
                sunit = c.unit_index;
                if (pend_n < TABLE_DEPTH)
                begin
                    pend_id[pend_n] = c.msg_id;
                    pend_unit[pend_n] = c.unit_index;
                    pend_stamp[pend_n] = c.now_ms;
                    pend_n++;
                    ok = 1'b1;
                end
            end
            OP_ACK:
            begin
                sid = c.msg_id;
                for (i = 0; i < pend_n; i++)
                begin
                    if (pend_id[i] == c.msg_id)
                    begin
                        sunit = pend_unit[i];
                        remove_pending(i);
                        ok = 1'b1;
                        break;
                    end
                end
            end
            OP_SCAN:
            begin
                // Ages wrap modulo 2^32; an aged entry stays put when the failed table is full.
                ok = 1'b1;
                i = 0;
                while (i < pend_n)
                begin
                    age = c.now_ms - pend_stamp[i];
                    if (age > timeout_reg && lost_n < TABLE_DEPTH)
                    begin
                        mid = pend_id[i];
                        mu = pend_unit[i];
                        lost_id[lost_n] = mid;
                        lost_unit[lost_n] = mu;
                        lost_tries[lost_n] = '0;
                        lost_n++;
                        remove_pending(i);
                        owe(KIND_MOVED, mid, mu, 1'b0, 1'b0);
                    end
                    else
                    begin
                        if (age > timeout_reg)
                            ok = 1'b0;
                        i++;
                    end
                end
            end
            OP_RETRY:
            begin
                // Resend goes out first; an entry past the retry limit then goes offline.
                ok = 1'b1;
                i = 0;
                while (i < lost_n)
                begin
                    mid = lost_id[i];
                    mu = lost_unit[i];
                    owe(KIND_RESEND, mid, mu, 1'b0, 1'b0);
                    lost_tries[i] = lost_tries[i] + 4'd1;
                    if (lost_tries[i] > {1'b0, retries_reg})
                    begin
                        remove_lost(i);
                        owe(KIND_OFFLINE, mid, mu, 1'b0, 1'b0);
                    end
                    else
                        i++;
                end
            end
            OP_RESTORE:
            begin
                sid = c.msg_id;
                for (i = 0; i < lost_n; i++)
                begin
                    if (lost_id[i] == c.msg_id)
                    begin
                        sunit = lost_unit[i];
                        if (pend_n < TABLE_DEPTH)
                        begin
                            pend_id[pend_n] = lost_id[i];
                            pend_unit[pend_n] = lost_unit[i];
                            pend_stamp[pend_n] = c.now_ms;
                            pend_n++;
                            remove_lost(i);
                            ok = 1'b1;
                        end
                        break;
                    end
                end
            end
            default:
                ok = 1'b0;
        endcase
        owe(KIND_STATUS, sid, sunit, ok, 1'b1);
    endfunction

    // Output side: random back-pressure, one long hold-off on request, and the checker.
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.msg_id = m_axis_tdata[31:0];
            got.unit = m_axis_tdata[39:32];
            got.ok = m_axis_tdata[40];
            got.waiting_level = m_axis_tdata[45:41];
            got.failed_level = m_axis_tdata[50:46];
            got.last = m_axis_tlast;
            if (owed_beats.size() == 0)
            begin
                $error("unexpected output beat kind=%0d id=%h", got.kind, got.msg_id);
                error_count++;
            end
            else
            begin
                want = owed_beats.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    error_count++;
                end
                if (got.msg_id !== want.msg_id)
                begin
                    $error("out_msg_id: expected %h, got %h", want.msg_id, got.msg_id);
                    error_count++;
                end
                if (got.unit !== want.unit)
                begin
                    $error("out_unit: expected %0d, got %0d", want.unit, got.unit);
                    error_count++;
                end
                if (got.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    error_count++;
                end
                if (got.waiting_level !== want.waiting_level)
                begin
                    $error("waiting_level: expected %0d, got %0d",
                           want.waiting_level, got.waiting_level);
                    error_count++;
                end
                if (got.failed_level !== want.failed_level)
                begin
                    $error("failed_level: expected %0d, got %0d",
                           want.failed_level, got.failed_level);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left = PRESSURE_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: a run that stops moving beats on both sides is hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ack_timeout_retry_tracker_unit verification failed");
            $finish;
        end
    end

    // Offers one command beat and waits for it to be taken; sender gaps fall in between.
    // Ready only changes at a rising edge, so it is sampled on the falling edge before.
    task automatic send_cmd(cmd_t c);
        logic accepted;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, c.now_ms, c.unit_index, c.msg_id, c.op};
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_axis_tready;
            @(posedge clk);
        end
        track_command(c);
    endtask

    // Lets the tracker drain every owed beat, then waits a while in silence.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIMEOUT)
            timeout_reg = value;
        else
            retries_reg = value[2:0];
    endtask

    // Random traffic. Most acknowledge and restore ids are picked from the live tables so they
    // actually hit; the clock advances steadily with an occasional wild jump.
    task automatic random_phase(int count, logic [31:0] start_ms);
        cmd_t        c;
        logic [31:0] clock_ms;
        int          pick;
        clock_ms = start_ms;
        for (int n = 0; n < count; n++)
        begin
            clock_ms += $urandom_range(0, 400);
            pick = $urandom_range(99);
            c.msg_id = $urandom();
            c.unit_index = 8'($urandom_range(255));
            c.now_ms = ($urandom_range(99) < 5) ? $urandom() : clock_ms;
            if (pick < 35)
                c.op = OP_ADD;
            else if (pick < 52)
                c.op = OP_ACK;
            else if (pick < 68)
                c.op = OP_SCAN;
            else if (pick < 83)
                c.op = OP_RETRY;
            else if (pick < 96)
                c.op = OP_RESTORE;
            else
                c.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            if (c.op == OP_ACK && pend_n > 0 && $urandom_range(99) < 80)
                c.msg_id = pend_id[$urandom_range(pend_n - 1)];
            if (c.op == OP_RESTORE && lost_n > 0 && $urandom_range(99) < 80)
                c.msg_id = lost_id[$urandom_range(lost_n - 1)];
            // Re-adding a live id now and then makes duplicates in the tables.
            if (c.op == OP_ADD && pend_n > 0 && $urandom_range(99) < 10)
                c.msg_id = pend_id[0];
            send_cmd(c);
        end
    endtask

    typedef struct {
        logic [2:0]  op;
        logic [31:0] msg_id;
        logic [7:0]  unit_index;
        logic [31:0] now_ms;
        bit          typed;
        logic [31:0] exp_id;
        logic [7:0]  exp_unit;
        logic        exp_ok;
        logic [4:0]  exp_wait;
        logic [4:0]  exp_fail;
    } row_t;

    // Directed rows. The closing status is typed in for the empty-table cases, an
    // undefined opcode and the first adds; every other row relies on the shadow model.
    row_t rows[] = '{
        '{OP_ACK,     32'd5,        8'd0,   32'd0,          1, 32'd5, 8'd0,   1'b0, 5'd0, 5'd0},
        '{OP_RESTORE, 32'd5,        8'd0,   32'd0,          1, 32'd5, 8'd0,   1'b0, 5'd0, 5'd0},
        '{OP_SCAN,    32'd0,        8'd0,   32'hFFFF_FFFF,  1, 32'd0, 8'd0,   1'b1, 5'd0, 5'd0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          1, 32'd0, 8'd0,   1'b1, 5'd0, 5'd0},
        '{OP_LAST_UNUSED, 32'd9,    8'd9,   32'd0,          1, 32'd0, 8'd0,   1'b0, 5'd0, 5'd0},
        '{OP_ADD,     32'd0,        8'd0,   32'd0,          1, 32'd0, 8'd0,   1'b1, 5'd1, 5'd0},
        '{OP_ADD,     32'hFFFF_FFFF, 8'hFF, 32'd0,          1, 32'hFFFF_FFFF, 8'hFF,
          1'b1, 5'd2, 5'd0},
        '{OP_ADD,     32'hFFFF_FFFF, 8'd1,  32'd50000,      0, '0, '0, '0, '0, '0},
        '{OP_ACK,     32'hFFFF_FFFF, 8'd0,  32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_SCAN,    32'd0,        8'd0,   32'd100000,     0, '0, '0, '0, '0, '0},
        '{OP_SCAN,    32'd0,        8'd0,   32'd100001,     0, '0, '0, '0, '0, '0},
        '{OP_RESTORE, 32'd0,        8'd0,   32'hFFFF_FF00,  0, '0, '0, '0, '0, '0},
        '{OP_SCAN,    32'd0,        8'd0,   32'd20000,      0, '0, '0, '0, '0, '0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_RETRY,   32'd0,        8'd0,   32'd0,          0, '0, '0, '0, '0, '0},
        '{OP_FIRST_UNUSED, 32'd1,   8'd1,   32'd1,          0, '0, '0, '0, '0, '0},
        '{OP_ACK,     32'h1234_5678, 8'd0,  32'd0,          0, '0, '0, '0, '0, '0}
    };

    initial
    begin
        cmd_t c;
        res_t typed_status;
        timeout_reg = TIMEOUT_RESET;
        retries_reg = RETRIES_RESET;
        pend_n = 0;
        lost_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the registers at their reset values.
        foreach (rows[k])
        begin
            c.op = rows[k].op;
            c.msg_id = rows[k].msg_id;
            c.unit_index = rows[k].unit_index;
            c.now_ms = rows[k].now_ms;
            send_cmd(c);
            if (rows[k].typed)
            begin
                typed_status.kind = KIND_STATUS;
                typed_status.msg_id = rows[k].exp_id;
                typed_status.unit = rows[k].exp_unit;
                typed_status.ok = rows[k].exp_ok;
                typed_status.waiting_level = rows[k].exp_wait;
                typed_status.failed_level = rows[k].exp_fail;
                typed_status.last = 1'b1;
                owed_beats[$] = typed_status;
            end
        end
        drain();

        // A very short timeout and no retries: almost everything fails.
        tx_idle_pct = 36;
        rx_idle_pct = 78;
        write_reg(REG_TIMEOUT, 32'd1);
        write_reg(REG_RETRIES, 32'd0);
        random_phase(30, 32'd0);
        drain();

        // Longest timeout and most retries, with the clock wrapping through zero.
        tx_idle_pct = 78;
        rx_idle_pct = 36;
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_RETRIES, 32'd7);
        random_phase(30, 32'hFFFF_F000);
        drain();

        // Middle settings at full rate; the output side holds off once for a long
        // stretch so the input queue fills and stalls the sender.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_TIMEOUT, 32'd700);
        write_reg(REG_RETRIES, 32'd2);
        hold_req <= 1'b1;
        random_phase(30, 32'd5000);
        drain();

        if (error_count == 0)
            $display("ack_timeout_retry_tracker_unit verification clean");
        else
            $display("ack_timeout_retry_tracker_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
